### rtl/wts_pkg.sv
// Shared types and constants of the window trend statistics block.
package wts_pkg;

  localparam int PERIOD_BITS = 7;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 7'd7;

  localparam int OUT_BITS = 16;
  localparam logic [OUT_BITS-1:0] OUT_MAX = 16'hFFFF;
  localparam logic [OUT_BITS-1:0] PCT_MAX = 16'd32767;
  localparam int PCT_SCALE = 100;

  localparam logic [1:0] DIR_DOWN = 2'd0;
  localparam logic [1:0] DIR_UP = 2'd1;
  localparam logic [1:0] DIR_UNKNOWN = 2'd2;

  typedef struct packed {
    logic rise_valid;
    logic [OUT_BITS-1:0] rise_mean;
    logic change_valid;
    logic signed [OUT_BITS-1:0] change_percent;
    logic divide_by_zero;
    logic spread_valid;
    logic [OUT_BITS-1:0] spread;
    logic trend_switch;
  } wts_result_t;

endpackage

### rtl/wts_sample_if.sv
// Sample input channel.
interface wts_sample_if #(parameter int SAMPLE_BITS = 16);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

### rtl/wts_cfg_if.sv
// Period register write channel.
interface wts_cfg_if;
  logic valid;
  logic ready;
  logic [wts_pkg::PERIOD_BITS-1:0] period;

  modport source(output valid, output period, input ready);
  modport sink(input valid, input period, output ready);
endinterface

### rtl/wts_result_if.sv
// Result output channel.
interface wts_result_if;
  logic valid;
  logic ready;
  wts_pkg::wts_result_t word;

  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

### rtl/wts_ram.sv
// Generic single write port RAM with registered read.
module wts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wts_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module wts_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quot
);

  localparam int CNTW = $clog2(W + 1);

  logic busy;
  logic [CNTW-1:0] cnt;
  logic [W:0] rem;
  logic [W-1:0] d;
  logic [W:0] sh;
  logic ge;
  logic [W:0] rem_next;

  always_comb begin
    sh = {rem[W-1:0], quot[W-1]};
    ge = (sh >= {1'b0, d});
    rem_next = ge ? (sh - {1'b0, d}) : sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        quot <= num;
        d <= den;
        cnt <= CNTW'(W);
      end else if (busy) begin
        rem <= rem_next;
        quot <= {quot[W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/wts_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module wts_sqrt #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   val,
  output logic           done,
  output logic [W/2-1:0] root
);

  logic busy;
  logic [W-1:0] v;
  logic [W-1:0] res;
  logic [W-1:0] bitv;
  logic [W:0] trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root = res[W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (bitv == W'(1));
      if (start) begin
        busy <= 1'b1;
        v <= val;
        res <= '0;
        bitv <= {2'b01, {(W-2){1'b0}}};
      end else if (busy) begin
        if ({1'b0, v} >= trial) begin
          v <= v - trial[W-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/window_trend_statistics_top.sv
// Window trend statistics: mean rise, percent change, spread and trend flips.
//
// Samples arrive on the samples channel, one signed Q8.8 word each; every
// accepted sample yields exactly one result word on the results channel.
// The setup channel writes the period register; it is ready only while the
// block is idle and must only be written while no sample is in flight. A
// write clears the sample history and the trend direction.
// The history sits in a RAM of MAX_WINDOW+1 entries. After a sample is
// written, the window is swept one entry per cycle, then a shared
// bit-serial divider of width DW runs up to three divisions and a square
// root follows, where DW = 2*SAMPLE_BITS + 2*clog2(MAX_WINDOW+1) + 2
// (48 by default). Before period samples have been seen, an item skips
// the sweep and the arithmetic. One item is in work at a time; the next
// is taken once the result sits in the output register. If the receiver
// stalls, the result is held and the block waits before loading the next
// one. Reset sets the period to 7 and clears the history; no RAM clearing
// pass is needed.
module window_trend_statistics_top #(
  parameter int MAX_WINDOW = 64,
  parameter int SAMPLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  wts_cfg_if.sink setup,
  wts_sample_if.sink samples,
  wts_result_if.source results
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int AW = $clog2(DEPTH);
  localparam int PCW = $clog2(MAX_WINDOW + 1);
  localparam int CW = $clog2(MAX_WINDOW + 2);
  localparam int SB = SAMPLE_BITS;
  localparam int SW = SB + PCW;
  localparam int QW = 2 * SB + PCW;
  localparam int DW = 2 * SB + 2 * PCW + 2;
  localparam int OB = wts_pkg::OUT_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_MUL = 4'd2;
  localparam logic [3:0] S_VAR = 4'd3;
  localparam logic [3:0] S_DR = 4'd4;
  localparam logic [3:0] S_DRW = 4'd5;
  localparam logic [3:0] S_DP = 4'd6;
  localparam logic [3:0] S_DPW = 4'd7;
  localparam logic [3:0] S_DV = 4'd8;
  localparam logic [3:0] S_DVW = 4'd9;
  localparam logic [3:0] S_SQW = 4'd10;
  localparam logic [3:0] S_FIN = 4'd11;

  logic [3:0] state;
  logic [wts_pkg::PERIOD_BITS-1:0] period;
  logic [PCW-1:0] peff;
  logic [PCW-1:0] p;
  logic [AW-1:0] wp;
  logic [AW-1:0] addr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] ik;
  logic [CW-1:0] dk;
  logic dv;
  logic [1:0] dir;
  logic rv;
  logic spv;
  logic signed [SB-1:0] prev;
  logic signed [SB-1:0] nv;
  logic signed [SB-1:0] ov;
  logic signed [SW-1:0] sum;
  logic [QW-1:0] sq;
  logic [SW-1:0] rise;
  logic [DW-1:0] pq;
  logic [DW-1:0] ss;
  logic [DW-1:0] p2;
  logic [DW-1:0] v4;
  logic [DW-1:0] rise_q;
  logic [DW-1:0] pct_q;
  logic [DW/2-1:0] troot;

  logic accept;
  logic signed [SB-1:0] rdata;
  logic signed [SB-1:0] x;
  logic [2*SB-1:0] xsq;
  logic signed [SB:0] xdiff;
  logic [SW-1:0] su;
  logic signed [SB:0] d;
  logic [SB:0] an;
  logic [SB:0] ad;
  logic neg;

  logic div_start;
  logic [DW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic div_done;
  logic [DW-1:0] div_quot;
  logic sq_start;
  logic sq_done;
  logic [DW/2-1:0] sq_root;

  wts_pkg::wts_result_t word_next;
  logic [1:0] dir_next;
  logic [DW/2:0] kround;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE) && !setup.valid;
  assign setup.ready = (state == S_IDLE);

  always_comb begin
    if (period == '0) begin
      peff = PCW'(1);
    end else if (32'(period) > MAX_WINDOW) begin
      peff = PCW'(MAX_WINDOW);
    end else begin
      peff = PCW'(period);
    end
    if (count < CW'(peff) + CW'(1)) begin
      count_next = count + CW'(1);
    end else begin
      count_next = CW'(peff) + CW'(1);
    end
  end

  wts_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram (
    .clk(clk),
    .we(accept),
    .waddr(wp),
    .wdata(samples.sample),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    x = rdata;
    xsq = x * x;
    xdiff = {prev[SB-1], prev} - {x[SB-1], x};
    su = sum[SW-1] ? SW'(-sum) : SW'(sum);
    d = {nv[SB-1], nv} - {ov[SB-1], ov};
    an = d[SB] ? (SB+1)'(-d) : (SB+1)'(d);
    ad = ov[SB-1] ? (SB+1)'(-{ov[SB-1], ov}) : (SB+1)'({ov[SB-1], ov});
    neg = d[SB] != ov[SB-1];
  end

  always_comb begin
    div_start = 1'b0;
    div_num = v4;
    div_den = p2;
    unique case (state)
      S_DR: begin
        div_start = 1'b1;
        div_num = (DW'(rise) << 1) + DW'(p);
        div_den = DW'(p) << 1;
      end
      S_DP: begin
        div_start = 1'b1;
        div_num = DW'(an) * DW'(2 * wts_pkg::PCT_SCALE) + DW'(ad);
        div_den = DW'(ad) << 1;
      end
      S_DV: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
    sq_start = (state == S_DVW) && div_done;
  end

  wts_div #(.W(DW)) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quot(div_quot)
  );

  wts_sqrt #(.W(DW)) u_sqrt (
    .clk(clk),
    .rst(rst),
    .start(sq_start),
    .val(div_quot),
    .done(sq_done),
    .root(sq_root)
  );

  always_comb begin
    logic below;
    logic above;
    logic [1:0] dcur;
    logic cv;
    logic [OB-1:0] q;
    below = (d != '0) && neg;
    above = (d != '0) && !neg;
    cv = rv && (ov != '0);
    dcur = dir;
    q = '0;
    dir_next = dir;
    word_next = '0;
    word_next.rise_valid = rv;
    word_next.change_valid = cv;
    word_next.divide_by_zero = rv && (ov == '0);
    word_next.spread_valid = spv;
    if (rv) begin
      word_next.rise_mean = (rise_q > DW'(wts_pkg::OUT_MAX)) ? wts_pkg::OUT_MAX
                                                             : OB'(rise_q);
    end
    if (cv) begin
      q = (pct_q > DW'(wts_pkg::PCT_MAX)) ? wts_pkg::PCT_MAX : OB'(pct_q);
      word_next.change_percent = neg ? -q : q;
      if (dcur == wts_pkg::DIR_UNKNOWN) begin
        dcur = below ? wts_pkg::DIR_DOWN : wts_pkg::DIR_UP;
      end
      word_next.trend_switch = (below && dcur == wts_pkg::DIR_UP) ||
                               (above && dcur == wts_pkg::DIR_DOWN);
      dir_next = below ? wts_pkg::DIR_DOWN : wts_pkg::DIR_UP;
    end
    kround = ({1'b0, troot} + (DW/2+1)'(1)) >> 1;
    if (spv) begin
      word_next.spread = (kround > (DW/2+1)'(wts_pkg::OUT_MAX)) ? wts_pkg::OUT_MAX
                                                                : OB'(kround);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      period <= wts_pkg::PERIOD_RESET;
      wp <= '0;
      count <= '0;
      dir <= wts_pkg::DIR_UNKNOWN;
      dv <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && (!results.valid || results.ready)) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (setup.valid && setup.ready) begin
        period <= setup.period;
        wp <= '0;
        count <= '0;
        dir <= wts_pkg::DIR_UNKNOWN;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            p <= peff;
            count <= count_next;
            addr <= wp;
            wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
            ik <= '0;
            dv <= 1'b0;
            sum <= '0;
            sq <= '0;
            rise <= '0;
            rv <= count_next > CW'(peff);
            spv <= count_next >= CW'(peff);
            state <= (count_next >= CW'(peff)) ? S_SWEEP : S_FIN;
          end
        end
        S_SWEEP: begin
          if (ik <= CW'(p)) begin
            addr <= (addr == '0) ? AW'(DEPTH - 1) : addr - AW'(1);
            ik <= ik + CW'(1);
            dk <= ik;
            dv <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            prev <= x;
            if (dk == '0) begin
              nv <= x;
            end
            if (dk < CW'(p)) begin
              sum <= sum + SW'(x);
              sq <= sq + QW'(xsq);
            end
            if ((dk != '0) && (xdiff > 0)) begin
              rise <= rise + SW'(xdiff[SB-1:0]);
            end
            if (dk == CW'(p)) begin
              ov <= x;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          pq <= DW'(p) * DW'(sq);
          ss <= DW'(su) * DW'(su);
          p2 <= DW'(p) * DW'(p);
          state <= S_VAR;
        end
        S_VAR: begin
          v4 <= (pq - ss) << 2;
          state <= rv ? S_DR : S_DV;
        end
        S_DR: begin
          state <= S_DRW;
        end
        S_DRW: begin
          if (div_done) begin
            rise_q <= div_quot;
            state <= (ov != '0) ? S_DP : S_DV;
          end
        end
        S_DP: begin
          state <= S_DPW;
        end
        S_DPW: begin
          if (div_done) begin
            pct_q <= div_quot;
            state <= S_DV;
          end
        end
        S_DV: begin
          state <= S_DVW;
        end
        S_DVW: begin
          if (div_done) begin
            state <= S_SQW;
          end
        end
        S_SQW: begin
          if (sq_done) begin
            troot <= sq_root;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!results.valid || results.ready) begin
            results.word <= word_next;
            dir <= dir_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
